### hw/rtl/two_class_graph_reachability_macros.svh
// assertion macros shared by the reachability rtl
// no dependencies; taken in by files that carry assertions
`ifndef TWO_CLASS_GRAPH_REACHABILITY_MACROS_SVH
`define TWO_CLASS_GRAPH_REACHABILITY_MACROS_SVH

// condition implies consequence in the same cycle
`define TCGR_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// condition implies consequence in the next cycle
`define TCGR_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

### hw/rtl/tcgr_pkg.sv
// types, codes and helpers for the two-class reachability block
// no dependencies
package tcgr_pkg;

    localparam int NODE_W = 10;

    typedef logic [NODE_W-1:0] node_t;

    localparam logic [2:0] FN_ADD2  = 3'd0;
    localparam logic [2:0] FN_ADD1  = 3'd1;
    localparam logic [2:0] FN_RUN   = 3'd2;
    localparam logic [2:0] FN_QUERY = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CL_LEGAL    = 2'd0;
    localparam logic [1:0] CL_REVERSED = 2'd1;
    localparam logic [1:0] CL_NONE     = 2'd2;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_START_NODE = 1'b1;

    typedef struct packed {
        logic [2:0] func;
        node_t      src_node;
        node_t      dst_node;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] node_class;
    } result_t;

    // edge word: one-way flag, destination, source
    typedef struct packed {
        logic  oneway;
        node_t dst;
        node_t src;
    } edge_t;

    typedef struct packed {
        logic  run;
        logic  query;
        node_t qnode;
        node_t start_node;
        node_t node_count;
    } eng_ctl_t;

    typedef struct packed {
        logic    done;
        result_t res;
    } eng_rsp_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_CLR,
        E_SEED,
        E_POP,
        E_POPW,
        E_RD,
        E_CHK,
        E_MD,
        E_SIS,
        E_MS,
        E_QW,
        E_FIN
    } eng_state_t;

    function automatic logic node_ok(node_t n, node_t cnt, int unsigned lim);
        return (n != '0) && (n <= cnt) && (32'(n) < lim);
    endfunction

endpackage

### hw/rtl/two_class_graph_reachability.sv
// top level: command decode, edge store, config registers, result register
// depends on tcgr_pkg, tcgr_engine and two_class_graph_reachability_macros.svh
//
//  channel   signals                              handshake
//  -------   ----------------------------------   ------------------------
//  command   start, busy, cmd                     start && !busy
//  result    done, result                         done, one cycle, no stall
//  config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//            cfg_data
//
// edge inserts, clear and unused codes answer in the cycle after acceptance and
// busy stays low, so a new beat can follow every cycle
// a query holds busy for one cycle and answers via E_QW and the done register
// a run clears every entry of both maps, then, if the start node is in range, for
// each map pass seeds the start node, pops each reached node and scans every stored
// edge for it through the single edge-store read port, then answers; reset clears
// control state but not the maps; queries answer no class until a run clears them
// results cannot be stalled; busy holds off command beats during run and query
`include "two_class_graph_reachability_macros.svh"

module two_class_graph_reachability
    import tcgr_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_index,
    input  node_t   cfg_data
);

    localparam int EW = $clog2(MAX_EDGES);

    // edge store, read only by the engine during a run
    edge_t edge_mem [MAX_EDGES];
    edge_t edge_rdata;

    logic [EW:0]   edge_total_reg, edge_total_next;
    node_t         node_count_reg, start_node_reg;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    logic          accept, eng_busy, full, src_ok, dst_ok, edge_we;
    logic [EW-1:0] edge_raddr;
    edge_t         edge_wdata;
    eng_ctl_t      eng_ctl;
    eng_rsp_t      eng_rsp;

    assign accept    = start && !busy;
    assign busy      = eng_busy;
    assign cfg_ready = !eng_busy;
    assign full      = (edge_total_reg == (EW+1)'(MAX_EDGES));
    assign src_ok    = node_ok(cmd.src_node, node_count_reg, MAX_NODES);
    assign dst_ok    = node_ok(cmd.dst_node, node_count_reg, MAX_NODES);

    assign eng_ctl.run        = accept && (cmd.func == FN_RUN);
    assign eng_ctl.query      = accept && (cmd.func == FN_QUERY);
    assign eng_ctl.qnode      = cmd.src_node;
    assign eng_ctl.start_node = start_node_reg;
    assign eng_ctl.node_count = node_count_reg;

    assign edge_wdata.oneway = (cmd.func == FN_ADD1);
    assign edge_wdata.dst    = cmd.dst_node;
    assign edge_wdata.src    = cmd.src_node;

    // decode of immediate beats; run and query answer through the engine
    always_comb
    begin
        edge_total_next = edge_total_reg;
        edge_we         = 1'b0;
        done_next       = eng_rsp.done;
        result_next     = eng_rsp.res;
        if (accept)
        begin
            case (cmd.func) inside
                FN_ADD2, FN_ADD1:
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    if (!src_ok || !dst_ok)
                        result_next.status = ST_RANGE;
                    else if (full)
                        result_next.status = ST_FULL;
                    else
                    begin
                        edge_we         = 1'b1;
                        edge_total_next = edge_total_reg + 1'b1;
                    end
                end
                FN_RUN, FN_QUERY:
                begin
                end
                FN_CLEAR:
                begin
                    done_next       = 1'b1;
                    result_next     = '0;
                    edge_total_next = '0;
                end
                default:
                begin
                    // unused codes: plain ok
                    done_next   = 1'b1;
                    result_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
            done_reg       <= 1'b0;
            node_count_reg <= node_t'(1023);
            start_node_reg <= node_t'(1);
        end
        else
        begin
            edge_total_reg <= edge_total_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NODE_COUNT: node_count_reg <= cfg_data;
                    CFG_START_NODE: start_node_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_total_reg[EW-1:0]] <= edge_wdata;
        edge_rdata <= edge_mem[edge_raddr];
    end

    tcgr_engine #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (eng_ctl),
        .edge_total (edge_total_reg),
        .edge_rdata (edge_rdata),
        .edge_raddr (edge_raddr),
        .rsp        (eng_rsp),
        .busy       (eng_busy)
    );

    assign done   = done_reg;
    assign result = result_reg;

    `TCGR_ASSERT_NOW(a_total_bound, clk, rst_n, 1'b1,
        edge_total_reg <= (EW+1)'(MAX_EDGES), "edge count past capacity")
    `TCGR_ASSERT_NEXT(a_run_busy, clk, rst_n, eng_ctl.run, busy,
        "run beat did not raise busy")
    `TCGR_ASSERT_NOW(a_rsp_busy, clk, rst_n, eng_rsp.done, !accept,
        "command beat taken during engine response")

endmodule

### hw/rtl/tcgr_engine.sv
// run and query engine: reachability maps, work stack, search sequencer
// depends on tcgr_pkg and two_class_graph_reachability_macros.svh
`include "two_class_graph_reachability_macros.svh"

module tcgr_engine
    import tcgr_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  eng_ctl_t                       ctl,
    input  logic [$clog2(MAX_EDGES):0]     edge_total,
    input  edge_t                          edge_rdata,
    output logic [$clog2(MAX_EDGES)-1:0]   edge_raddr,
    output eng_rsp_t                       rsp,
    output logic                           busy
);

    localparam int NIW = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES);

    // bit 0 legal map, bit 1 any map
    logic [1:0] map_mem [MAX_NODES];
    node_t      stack_mem [MAX_NODES];
    logic [1:0] map_q;
    node_t      stack_q;

    eng_state_t     state_reg, state_next;
    logic           pass_reg, pass_next;
    logic [NIW-1:0] clr_reg, clr_next;
    logic [NIW:0]   sp_reg, sp_next;
    node_t          node_reg, node_next;
    node_t          qnode_reg, qnode_next;
    logic [EW:0]    eidx_reg, eidx_next;
    edge_t          edge_reg, edge_next;
    logic           hits_reg, hits_next;
    logic           maps_ok_reg, maps_ok_next;

    logic           map_we, stk_we;
    logic [NIW-1:0] map_raddr, map_waddr, stk_raddr;
    logic [1:0]     map_wdata;
    node_t          stk_wdata;

    logic           start_ok, e_vld, hit_d, hit_s, seen;
    logic [1:0]     mask;

    assign start_ok = node_ok(ctl.start_node, ctl.node_count, MAX_NODES);
    assign e_vld    = node_ok(edge_rdata.src, ctl.node_count, MAX_NODES)
                   && node_ok(edge_rdata.dst, ctl.node_count, MAX_NODES);
    assign hit_d    = e_vld && (edge_rdata.src == node_reg);
    assign hit_s    = e_vld && (edge_rdata.dst == node_reg)
                   && (!edge_rdata.oneway || pass_reg);
    assign mask     = pass_reg ? 2'b10 : 2'b01;
    assign seen     = (map_q & mask) != 2'b00;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (ctl.run)
                    state_next = E_CLR;
                else if (ctl.query)
                    state_next = E_QW;
            end
            E_CLR:
            begin
                if (clr_reg == NIW'(MAX_NODES - 1))
                    state_next = start_ok ? E_SEED : E_FIN;
            end
            E_SEED: state_next = E_POP;
            E_POP:
            begin
                if (sp_reg == '0)
                    state_next = pass_reg ? E_FIN : E_SEED;
                else
                    state_next = E_POPW;
            end
            E_POPW: state_next = E_RD;
            E_RD:   state_next = (eidx_reg == edge_total) ? E_POP : E_CHK;
            E_CHK:
            begin
                if (hit_d)
                    state_next = E_MD;
                else if (hit_s)
                    state_next = E_MS;
                else
                    state_next = E_RD;
            end
            E_MD:   state_next = hits_reg ? E_SIS : E_RD;
            E_SIS:  state_next = E_MS;
            E_MS:   state_next = E_RD;
            E_QW:   state_next = E_IDLE;
            E_FIN:  state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    // memory controls and response
    always_comb
    begin
        map_we     = 1'b0;
        map_waddr  = NIW'(node_reg);
        map_wdata  = map_q | mask;
        map_raddr  = NIW'(ctl.qnode);
        stk_we     = 1'b0;
        stk_wdata  = edge_reg.dst;
        stk_raddr  = NIW'(sp_reg - 1'b1);
        edge_raddr = eidx_reg[EW-1:0];
        rsp        = '0;
        unique case (state_reg)
            E_CLR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = 2'b00;
            end
            E_SEED:
            begin
                map_we    = 1'b1;
                map_waddr = NIW'(ctl.start_node);
                map_wdata = pass_reg ? 2'b11 : 2'b01;
                stk_we    = 1'b1;
                stk_wdata = ctl.start_node;
            end
            E_CHK:
            begin
                map_raddr = hit_d ? NIW'(edge_rdata.dst) : NIW'(edge_rdata.src);
            end
            E_MD:
            begin
                map_we    = !seen;
                map_waddr = NIW'(edge_reg.dst);
                stk_we    = !seen;
                stk_wdata = edge_reg.dst;
            end
            E_SIS:
            begin
                map_raddr = NIW'(edge_reg.src);
            end
            E_MS:
            begin
                map_we    = !seen;
                map_waddr = NIW'(edge_reg.src);
                stk_we    = !seen;
                stk_wdata = edge_reg.src;
            end
            E_QW:
            begin
                rsp.done = 1'b1;
                if (!node_ok(qnode_reg, ctl.node_count, MAX_NODES))
                begin
                    rsp.res.status     = ST_RANGE;
                    rsp.res.node_class = CL_NONE;
                end
                else if (!maps_ok_reg)
                    rsp.res.node_class = CL_NONE;
                else if (map_q[0])
                    rsp.res.node_class = CL_LEGAL;
                else if (map_q[1])
                    rsp.res.node_class = CL_REVERSED;
                else
                    rsp.res.node_class = CL_NONE;
            end
            E_FIN:
            begin
                rsp.done       = 1'b1;
                rsp.res.status = start_ok ? ST_OK : ST_RANGE;
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        pass_next    = pass_reg;
        clr_next     = clr_reg;
        sp_next      = sp_reg;
        node_next    = node_reg;
        qnode_next   = qnode_reg;
        eidx_next    = eidx_reg;
        edge_next    = edge_reg;
        hits_next    = hits_reg;
        maps_ok_next = maps_ok_reg;
        case (state_reg)
            E_IDLE:
            begin
                qnode_next = ctl.qnode;
                clr_next   = '0;
                pass_next  = 1'b0;
                sp_next    = '0;
            end
            E_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NIW'(MAX_NODES - 1))
                    maps_ok_next = 1'b1;
            end
            E_SEED: sp_next = (NIW+1)'(1);
            E_POP:
            begin
                if (sp_reg == '0)
                    pass_next = 1'b1;
                else
                    sp_next = sp_reg - 1'b1;
            end
            E_POPW:
            begin
                node_next = stack_q;
                eidx_next = '0;
            end
            E_CHK:
            begin
                edge_next = edge_rdata;
                hits_next = hit_s;
                if (!hit_d && !hit_s)
                    eidx_next = eidx_reg + 1'b1;
            end
            E_MD:
            begin
                if (!seen)
                    sp_next = sp_reg + 1'b1;
                if (!hits_reg)
                    eidx_next = eidx_reg + 1'b1;
            end
            E_MS:
            begin
                if (!seen)
                    sp_next = sp_reg + 1'b1;
                eidx_next = eidx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= E_IDLE;
            pass_reg    <= 1'b0;
            clr_reg     <= '0;
            sp_reg      <= '0;
            eidx_reg    <= '0;
            hits_reg    <= 1'b0;
            maps_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            eidx_reg    <= eidx_next;
            hits_reg    <= hits_next;
            maps_ok_reg <= maps_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        qnode_reg <= qnode_next;
        edge_reg  <= edge_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        map_q <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[sp_reg[NIW-1:0]] <= stk_wdata;
        stack_q <= stack_mem[stk_raddr];
    end

    assign busy = (state_reg != E_IDLE);

    `TCGR_ASSERT_NOW(a_sp_bound, clk, rst_n, 1'b1, sp_reg <= (NIW+1)'(MAX_NODES),
        "work stack overflow")
    `TCGR_ASSERT_NOW(a_push_marks, clk, rst_n, stk_we, map_we,
        "stack push without map mark")
    `TCGR_ASSERT_NEXT(a_done_idle, clk, rst_n, rsp.done, state_reg == E_IDLE,
        "engine not idle after response")

endmodule
